[src/mapt_pkg.sv]
// ----------------------------------------------------------------------------
// mapt_pkg
// Shared types and constants for the link address prefix translator.
// ----------------------------------------------------------------------------
package mapt_pkg;

  // prefix table geometry
  localparam int TBL_ENTRIES = 32;
  localparam int TABLE_DEPTH = 32;
  localparam int TBL_AW      = $clog2(TBL_ENTRIES);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PFX_W       = 24;

  // low three bits of byte 0 that mark a translated address
  localparam logic [2:0] TAG_XLAT = 3'b110;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OWN_ETH    = 3'd0,
    REG_OWN_RADIO  = 3'd1,
    REG_OWN_VALID  = 3'd2,
    REG_FILLER_A   = 3'd3,
    REG_FILLER_B   = 3'd4
  } cfg_reg_t;

  // opcodes
  localparam logic OP_ETH2RADIO = 1'b0;
  localparam logic OP_RADIO2ETH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic        opcode;
    logic [63:0] addr_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] addr_out;
    logic        ok;
  } out_item_t;

endpackage

[src/mac_address_prefix_translator.sv]
// ----------------------------------------------------------------------------
// mac_address_prefix_translator
// Translates link addresses between 48-bit Ethernet and 64-bit radio format.
// ----------------------------------------------------------------------------
// Usage:
//   An item (opcode, addr_in) is taken at a clock edge with start high and
//   busy low. Its single result appears on out_data for exactly one cycle
//   with out_valid high; the receiver cannot stall, so it must take it then.
//   Configuration (register index and data) goes in over cfg_valid/cfg_ready
//   (always ready); the user must write only while idle (not enforced).
// Timing:
//   Ethernet to radio, and radio addresses that hit the own pair or the
//   filler bytes or meet an empty table, finish in decode: the prefix table
//   is read as the item is taken and the result is registered in decode. A
//   radio address that needs the table walks the prefix memory one entry
//   per cycle, comparing 1..32 entries. A learned prefix is written in the
//   last decode or scan cycle, before busy drops.
// Reset:
//   rst_n is synchronous and active low. It clears the configuration and the
//   prefix count; entries at or above the count read as a zero prefix, so
//   the table memory needs no clearing pass.
// ----------------------------------------------------------------------------
module mac_address_prefix_translator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  mapt_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  output mapt_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mapt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mapt_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic [47:0] own_eth_r;
  logic [63:0] own_radio_r;
  logic        own_valid_r;
  logic [7:0]  filler_a_r;
  logic [7:0]  filler_b_r;

  // control and item state
  mapt_pkg::state_t               state_r, state_nxt;
  mapt_pkg::in_item_t             in_r;
  logic [mapt_pkg::TBL_AW-1:0]    scan_r, scan_nxt;
  logic [mapt_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic                           out_valid_r, out_valid_nxt;
  mapt_pkg::out_item_t            out_data_r, out_data_nxt;

  // prefix memory
  logic [mapt_pkg::PFX_W-1:0]     tbl_mem [mapt_pkg::TBL_ENTRIES];
  logic [mapt_pkg::PFX_W-1:0]     rd_data_r;
  logic [mapt_pkg::TBL_AW-1:0]    rd_addr;
  logic                           wr_en;

  // decode terms
  logic                           accept;
  logic [47:0]                    eth;
  logic [mapt_pkg::TBL_AW-1:0]    fwd_idx;
  logic                           is_tag;
  logic                           fwd_known;
  logic                           own_fwd;
  logic                           own_rev;
  logic                           fill_hit;
  logic [mapt_pkg::PFX_W-1:0]     pfx;
  logic                           count_zero;
  logic                           table_full;
  logic                           hit;
  logic                           last;
  logic                           dec_done;
  logic                           scan_done;
  logic                           miss;
  logic [mapt_pkg::TBL_AW-1:0]    rev_idx;

  assign accept    = start && !busy;
  assign busy      = (state_r != mapt_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // field decode of the held item
  assign eth        = in_r.addr_in[47:0];
  assign fwd_idx    = eth[47:43];
  assign is_tag     = (eth[42:40] == mapt_pkg::TAG_XLAT);
  assign fwd_known  = ({1'b0, fwd_idx} < count_r);
  assign own_fwd    = (eth == own_eth_r);
  assign own_rev    = own_valid_r && (in_r.addr_in == own_radio_r);
  assign fill_hit   = (in_r.addr_in[39:32] == filler_a_r) &&
                      (in_r.addr_in[31:24] == filler_b_r);
  assign pfx        = in_r.addr_in[63:40];
  assign count_zero = (count_r == '0);
  assign table_full = (count_r >= mapt_pkg::CNT_W'(mapt_pkg::TABLE_DEPTH));
  assign hit        = (rd_data_r == pfx);
  assign last       = ({1'b0, scan_r} + mapt_pkg::CNT_W'(1)) == count_r;

  // the item finishes in decode unless the table has to be walked
  assign dec_done  = (state_r == mapt_pkg::ST_DECODE) &&
                     ((in_r.opcode == mapt_pkg::OP_ETH2RADIO) || own_rev ||
                      fill_hit || count_zero);
  assign scan_done = (state_r == mapt_pkg::ST_SCAN) && (hit || last);
  assign miss      = ((state_r == mapt_pkg::ST_DECODE) &&
                      (in_r.opcode == mapt_pkg::OP_RADIO2ETH) &&
                      !own_rev && !fill_hit && count_zero) ||
                     ((state_r == mapt_pkg::ST_SCAN) && !hit && last);
  assign wr_en     = miss && !table_full;
  assign rev_idx   = (miss) ? count_r[mapt_pkg::TBL_AW-1:0] : scan_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mapt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = mapt_pkg::ST_DECODE;
        end
      end
      mapt_pkg::ST_DECODE: begin
        state_nxt = dec_done ? mapt_pkg::ST_IDLE : mapt_pkg::ST_SCAN;
      end
      mapt_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = mapt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mapt_pkg::ST_IDLE;
    endcase
  end

  // memory address, scan pointer, count and result
  always_comb begin
    rd_addr       = in_data.addr_in[47:43];
    scan_nxt      = scan_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      mapt_pkg::ST_IDLE: begin
        rd_addr = in_data.addr_in[47:43];
      end
      mapt_pkg::ST_DECODE: begin
        rd_addr  = '0;
        scan_nxt = '0;
      end
      mapt_pkg::ST_SCAN: begin
        rd_addr  = scan_r + mapt_pkg::TBL_AW'(1);
        scan_nxt = scan_r + mapt_pkg::TBL_AW'(1);
      end
      default: begin
        rd_addr = '0;
      end
    endcase

    if (wr_en) begin
      count_nxt = count_r + mapt_pkg::CNT_W'(1);
    end

    if (dec_done || scan_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt.ok = 1'b1;
      if (in_r.opcode == mapt_pkg::OP_ETH2RADIO) begin
        if (own_fwd) begin
          out_data_nxt.addr_out = own_radio_r;
        end else if (is_tag) begin
          out_data_nxt.addr_out = {(fwd_known ? rd_data_r : mapt_pkg::PFX_W'(0)),
                                   eth[39:0]};
          out_data_nxt.ok       = fwd_known;
        end else begin
          out_data_nxt.addr_out = {eth[47:24], filler_a_r, filler_b_r, eth[23:0]};
        end
      end else if (own_rev) begin
        out_data_nxt.addr_out = {16'h0000, own_eth_r};
      end else if (fill_hit || (miss && table_full)) begin
        out_data_nxt.addr_out = {16'h0000, pfx, in_r.addr_in[23:0]};
        out_data_nxt.ok       = fill_hit;
      end else begin
        out_data_nxt.addr_out = {16'h0000, rev_idx, mapt_pkg::TAG_XLAT,
                                 in_r.addr_in[39:0]};
      end
    end
  end

  // prefix memory: one write and one read per cycle, read data registered;
  // a learned entry is written before busy drops, so the next read sees it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[count_r[mapt_pkg::TBL_AW-1:0]] <= pfx;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mapt_pkg::ST_IDLE;
      count_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_eth_r   <= '0;
      own_radio_r <= '0;
      own_valid_r <= 1'b0;
      filler_a_r  <= '0;
      filler_b_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mapt_pkg::REG_OWN_ETH:   own_eth_r   <= cfg_data[47:0];
        mapt_pkg::REG_OWN_RADIO: own_radio_r <= cfg_data;
        mapt_pkg::REG_OWN_VALID: own_valid_r <= cfg_data[0];
        mapt_pkg::REG_FILLER_A:  filler_a_r  <= cfg_data[7:0];
        mapt_pkg::REG_FILLER_B:  filler_b_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[src/mapt_checker.sv]
// ----------------------------------------------------------------------------
// mapt_checker
// Port-level checks on the item handshake and result strobe of the translator.
// ----------------------------------------------------------------------------
module mapt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // an accepted item raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after item accept");

  // results are shown only once the item is finished
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every finished item gives its result right away
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // one result per item, never on back-to-back cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  // a result always follows a cycle spent working on its item
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in progress");

endmodule

bind mac_address_prefix_translator mapt_checker u_mapt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link address prefix translator. Items go in on
// the start/busy command port, and every result strobe is compared against a
// local translation predictor that keeps its own copy of the registers and of
// the learned prefix table. Directed items cover own-address matches, filler
// insertion and removal, known and unknown table indexes and prefix learning.
// The random part mixes translated, own, filler and pooled-prefix addresses
// under several register settings and sender idle rates.
// ----------------------------------------------------------------------------
module tb_top;

  // translation predictor and pending result store
  class addr_xlat_checker;
    logic [47:0]         own_eth;
    logic [63:0]         own_radio;
    logic                own_valid;
    logic [7:0]          fill_a;
    logic [7:0]          fill_b;
    logic [23:0]         pfx_tbl [mapt_pkg::TBL_ENTRIES];
    int                  pfx_cnt;
    mapt_pkg::out_item_t exp_xlat [$];
    int                  mismatches;

    function new();
      own_eth    = '0;
      own_radio  = '0;
      own_valid  = 1'b0;
      fill_a     = '0;
      fill_b     = '0;
      pfx_cnt    = 0;
      mismatches = 0;
      foreach (pfx_tbl[i]) pfx_tbl[i] = '0;
    endfunction

    function void set_reg(logic [mapt_pkg::CFG_IDX_W-1:0] idx,
                          logic [mapt_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mapt_pkg::REG_OWN_ETH:   own_eth   = data[47:0];
        mapt_pkg::REG_OWN_RADIO: own_radio = data;
        mapt_pkg::REG_OWN_VALID: own_valid = data[0];
        mapt_pkg::REG_FILLER_A:  fill_a    = data[7:0];
        mapt_pkg::REG_FILLER_B:  fill_b    = data[7:0];
        default: ;
      endcase
    endfunction

    // expected result of one item; learns new prefixes as the block does
    function mapt_pkg::out_item_t predict_translation(mapt_pkg::in_item_t it);
      logic [47:0]         eth;
      logic [63:0]         a;
      logic [7:0]          b0;
      logic [4:0]          slot;
      logic [23:0]         pfx;
      int                  hit;
      mapt_pkg::out_item_t r;
      r.ok = 1'b1;
      a    = it.addr_in;
      if (it.opcode == mapt_pkg::OP_ETH2RADIO) begin
        eth = a[47:0];
        b0  = eth[47:40];
        if (eth == own_eth) begin
          r.addr_out = own_radio;
        end else if (b0[2:0] == mapt_pkg::TAG_XLAT) begin
          slot       = b0[7:3];
          r.addr_out = {pfx_tbl[slot], eth[39:0]};
          if (int'(slot) >= pfx_cnt) r.ok = 1'b0;
        end else begin
          r.addr_out = {eth[47:24], fill_a, fill_b, eth[23:0]};
        end
      end else begin
        if (own_valid && a == own_radio) begin
          r.addr_out = {16'h0, own_eth};
        end else if (a[39:32] == fill_a && a[31:24] == fill_b) begin
          r.addr_out = {16'h0, a[63:40], a[23:0]};
        end else begin
          pfx = a[63:40];
          hit = -1;
          for (int i = 0; i < pfx_cnt; i++)
            if (hit < 0 && pfx_tbl[i] == pfx) hit = i;
          if (hit < 0 && pfx_cnt >= mapt_pkg::TABLE_DEPTH) begin
            // table full: plain copy, nothing learned
            r.addr_out = {16'h0, a[63:40], a[23:0]};
            r.ok       = 1'b0;
          end else begin
            if (hit < 0) begin
              hit          = pfx_cnt;
              pfx_tbl[hit] = pfx;
              pfx_cnt++;
            end
            slot       = hit[4:0];
            r.addr_out = {16'h0, slot, mapt_pkg::TAG_XLAT, a[39:0]};
          end
        end
      end
      return r;
    endfunction

    function void note_input(mapt_pkg::in_item_t it);
      exp_xlat.push_back(predict_translation(it));
    endfunction

    function void check_result(mapt_pkg::out_item_t got);
      mapt_pkg::out_item_t want;
      if (exp_xlat.size() == 0) begin
        $display("%0t: result expected none actual addr_out %h ok %b",
                 $time, got.addr_out, got.ok);
        mismatches++;
      end else begin
        want = exp_xlat.pop_front();
        if (got.addr_out !== want.addr_out) begin
          $display("%0t: addr_out expected %h actual %h", $time, want.addr_out, got.addr_out);
          mismatches++;
        end
        if (got.ok !== want.ok) begin
          $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return exp_xlat.size();
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  mapt_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  mapt_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [mapt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mapt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  addr_xlat_checker sb = new();
  logic [23:0]      pfx_pool [48];

  always #5 clk = ~clk;

  mac_address_prefix_translator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  // run limit
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // start stays high into the next item unless a gap follows
  task automatic send(logic op, logic [63:0] addr);
    mapt_pkg::in_item_t it;
    it.opcode  = op;
    it.addr_in = addr;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(start && !busy));
    sb.note_input(it);
  endtask

  task automatic idle_gap(int pct);
    int n;
    n = 0;
    while (int'($urandom_range(99)) < pct) n++;
    if (n > 0) begin
      start   <= 1'b0;
      in_data <= {1'($urandom_range(1)), rand64()};
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every result is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_reg(logic [mapt_pkg::CFG_IDX_W-1:0] idx,
                           logic [mapt_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [63:0] eth, logic [63:0] radio, logic [63:0] vld,
                              logic [63:0] fa, logic [63:0] fb);
    write_reg(mapt_pkg::REG_OWN_ETH, eth);
    write_reg(mapt_pkg::REG_OWN_RADIO, radio);
    write_reg(mapt_pkg::REG_OWN_VALID, vld);
    write_reg(mapt_pkg::REG_FILLER_A, fa);
    write_reg(mapt_pkg::REG_FILLER_B, fb);
    cfg_valid <= 1'b0;
  endtask

  // random item drawn from the interesting address classes
  task automatic send_random();
    logic [63:0] a;
    int          pick;
    a    = rand64();
    pick = $urandom_range(99);
    if (pick < 10) begin
      a[47:0] = sb.own_eth;
      send(mapt_pkg::OP_ETH2RADIO, a);
    end else if (pick < 40) begin
      a[42:40] = mapt_pkg::TAG_XLAT;
      send(mapt_pkg::OP_ETH2RADIO, a);
    end else if (pick < 55) begin
      send(mapt_pkg::OP_ETH2RADIO, a);
    end else if (pick < 63) begin
      send(mapt_pkg::OP_RADIO2ETH, sb.own_radio);
    end else if (pick < 73) begin
      a[39:24] = {sb.fill_a, sb.fill_b};
      send(mapt_pkg::OP_RADIO2ETH, a);
    end else if (pick < 93) begin
      a[63:40] = pfx_pool[$urandom_range(47)];
      send(mapt_pkg::OP_RADIO2ETH, a);
    end else begin
      send(mapt_pkg::OP_RADIO2ETH, a);
    end
  endtask

  task automatic run_random(int n, int pct);
    for (int i = 0; i < n; i++) begin
      idle_gap(pct);
      send_random();
    end
  endtask

  initial begin
    pfx_pool[0] = 24'h000000;
    pfx_pool[1] = 24'hFFFFFF;
    for (int i = 2; i < 48; i++) pfx_pool[i] = 24'($urandom);

    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset values: own pair all zero, fillers zero
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_0000_0000_0000);
    send(mapt_pkg::OP_ETH2RADIO, 64'hFFFF_FFFF_FFFF_FFFF);
    send(mapt_pkg::OP_RADIO2ETH, 64'h0000_0000_0000_0000);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_0600_0000_0001);
    send(mapt_pkg::OP_RADIO2ETH, 64'hABCD_EF01_0000_0000);
    send(mapt_pkg::OP_RADIO2ETH, 64'hABCD_EF02_0300_0000);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_06AA_BBCC_DDEE);
    send(mapt_pkg::OP_RADIO2ETH, 64'hFFFF_FFFF_FFFF_FFFF);
    send(mapt_pkg::OP_RADIO2ETH, 64'h0600_0000_0012_3456);
    drain();

    // own mac looks like a translated address, own radio carries the fillers
    program_regs(64'h0000_0E12_3456_789A, 64'h0211_225A_C333_4455, 64'h1,
                 64'h5A, 64'hC3);
    send(mapt_pkg::OP_ETH2RADIO, 64'hFFFF_0E12_3456_789A);
    send(mapt_pkg::OP_RADIO2ETH, 64'h0211_225A_C333_4455);
    send(mapt_pkg::OP_RADIO2ETH, 64'h0211_225A_C333_4454);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_0E00_0000_0001);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_1600_1122_3344);
    send(mapt_pkg::OP_RADIO2ETH, 64'h1234_5600_0000_0000);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_1699_8877_6655);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_0011_2233_4455);
    send(mapt_pkg::OP_ETH2RADIO, 64'h0000_FE01_0203_0405);

    // back to back, no idling
    run_random(200, 0);
    drain();

    // random registers, sender mostly idle
    program_regs(rand64(), rand64(), rand64(), rand64(), rand64());
    run_random(200, 62);
    drain();

    // all ones, light idling with a full pause in the middle
    program_regs('1, '1, '1, '1, '1);
    run_random(75, 20);
    drain();
    run_random(75, 20);
    drain();

    // all zeros, own radio match disabled
    program_regs('0, '0, '0, '0, '0);
    run_random(150, 0);
    drain();

    // random registers plus writes to unused indexes, which change nothing
    for (int k = int'(mapt_pkg::REG_FILLER_B) + 1; k < (1 << mapt_pkg::CFG_IDX_W); k++)
      write_reg(k[mapt_pkg::CFG_IDX_W-1:0], rand64());
    program_regs(rand64(), rand64(), 64'h1, rand64(), rand64());
    run_random(150, 62);
    drain();

    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
